/* sv/mvr_pkg.sv */
// ----------------------------------------------------------------------------
// mvr_pkg
// Shared types and codes for the matrix-vector residual block
// ----------------------------------------------------------------------------
package mvr_pkg;

	// item kinds carried on the input tuser
	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_X  = 2'd1,
		ACT_LOAD_B  = 2'd2,
		ACT_COMPUTE = 2'd3
	} action_t;

	localparam int unsigned IDX_BITS  = 4;
	localparam int unsigned DATA_BITS = 32;
	localparam int unsigned SIZE_BITS = 5;
	localparam int unsigned ACC_BITS  = 64;
	localparam int unsigned FRAC_BITS = 16;

	// controller to datapath
	typedef struct packed {
		logic issue;     // read one a/x pair this cycle
		logic first;     // first column of a row
		logic last;      // last column of a row
		logic last_row;  // row being issued is the final one
		logic wr_a;
		logic wr_x;
		logic wr_b;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic row_done;  // a row result enters the output register
		logic out_free;  // output register empty or emptied this cycle
	} stat_t;

endpackage

/* sv/matrix_vector_residual.sv */
// ----------------------------------------------------------------------------
// matrix_vector_residual
// Loads a square matrix and two vectors, then streams y = A*x - b row by row
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser action, tdata row/col/value
//  m_*       out        m_tvalid/m_tready  tuser saturated, tlast, tdata row/res
//  cfg_*     in         cfg_valid/ready    cfg_data order of the system
//
//  load items write the element stores directly.
//  for a compute of order n each row has a start state, n multiply-accumulate
//  issues and a drain through the read, product, sum and difference registers
//  into the output register; a row only starts when that register is free.
//  reset clears control state and sets the order to 16; stores hold no reset.
//  a stall on the output delays the next row; input waits for the last row.
// ----------------------------------------------------------------------------
module matrix_vector_residual #(
	parameter int unsigned MAX_ORDER  = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,   // size_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // row[3:0], col[7:4], value[39:8]
	input  logic [1:0]  s_tuser,    // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // row_out[3:0], residual[35:4], zero pad
	output logic [0:0]  m_tuser,    // saturated[0]
	output logic        m_tlast
);

	localparam int unsigned IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int unsigned CW = $clog2(MAX_ORDER + 1);
	localparam int unsigned AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;

	mvr_pkg::cmd_t  cmd;
	mvr_pkg::stat_t stat;
	logic [IW-1:0]  rd_row;
	logic [IW-1:0]  rd_col;
	logic [3:0]     row_out;
	logic [31:0]    residual;
	logic           saturated;

	assign cfg_ready = 1'b1;

	mvr_ctrl #(
		.MAX_ORDER (MAX_ORDER),
		.IW        (IW),
		.CW        (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.action    (s_tuser),
		.ld_row    (s_tdata[3:0]),
		.ld_col    (s_tdata[7:4]),
		.rd_row    (rd_row),
		.rd_col    (rd_col),
		.cmd       (cmd),
		.stat      (stat)
	);

	mvr_datapath #(
		.MAX_ORDER  (MAX_ORDER),
		.VALUE_BITS (VALUE_BITS),
		.IW         (IW),
		.AW         (AW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_row    (rd_row),
		.rd_col    (rd_col),
		.ld_row    (s_tdata[3:0]),
		.ld_col    (s_tdata[7:4]),
		.ld_value  (s_tdata[39:8]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.row_out   (row_out),
		.residual  (residual),
		.saturated (saturated),
		.last      (m_tlast),
		.stat      (stat)
	);

	assign m_tdata = {4'b0000, residual, row_out};
	assign m_tuser = saturated;

endmodule

/* sv/mvr_ctrl.sv */
// ----------------------------------------------------------------------------
// mvr_ctrl
// Sequencer: takes items and the order register, walks rows and columns
// ----------------------------------------------------------------------------
module mvr_ctrl #(
	parameter int unsigned MAX_ORDER = 16,
	parameter int unsigned IW        = 4,
	parameter int unsigned CW        = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [mvr_pkg::SIZE_BITS-1:0]   cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [1:0]                      action,
	input  logic [mvr_pkg::IDX_BITS-1:0]    ld_row,
	input  logic [mvr_pkg::IDX_BITS-1:0]    ld_col,
	output logic [IW-1:0]                   rd_row,
	output logic [IW-1:0]                   rd_col,
	output mvr_pkg::cmd_t                   cmd,
	input  mvr_pkg::stat_t                  stat
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_ISSUE = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	localparam logic [6:0] MaxOrd = 7'(MAX_ORDER);

	state_t                         state_q;
	logic [IW-1:0]                  i_q;
	logic [IW-1:0]                  j_q;
	logic [CW-1:0]                  n_q;
	logic [mvr_pkg::SIZE_BITS-1:0]  size_q;
	logic [CW-1:0]                  n_eff;
	logic                           accept;
	logic                           col_last;
	logic                           row_last;
	logic                           row_ok;
	logic                           col_ok;
	logic                           is_compute;

	// order 0 acts as 1, anything above the store size as the store size
	always_comb begin
		if (size_q == '0) begin
			n_eff = CW'(1);
		end else if ({2'b00, size_q} > MaxOrd) begin
			n_eff = CW'(MAX_ORDER);
		end else begin
			n_eff = CW'(size_q);
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign col_last   = (CW'(j_q) + CW'(1)) == n_q;
	assign row_last   = (CW'(i_q) + CW'(1)) == n_q;
	assign row_ok     = {3'b000, ld_row} < MaxOrd;
	assign col_ok     = {3'b000, ld_col} < MaxOrd;
	assign is_compute = (action == mvr_pkg::ACT_COMPUTE);

	assign rd_row = i_q;
	assign rd_col = j_q;

	always_comb begin
		cmd          = '0;
		cmd.issue    = (state_q == ST_ISSUE);
		cmd.first    = (j_q == '0);
		cmd.last     = col_last;
		cmd.last_row = row_last;
		if (accept) begin
			unique case (action)
				mvr_pkg::ACT_LOAD_A: cmd.wr_a = row_ok && col_ok;
				mvr_pkg::ACT_LOAD_X: cmd.wr_x = row_ok;
				mvr_pkg::ACT_LOAD_B: cmd.wr_b = row_ok;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= mvr_pkg::SIZE_BITS'(16);
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= CW'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_compute) begin
						n_q     <= n_eff;
						i_q     <= '0;
						state_q <= ST_START;
					end
				end
				// one row in flight at a time, started only into a free output slot
				ST_START: begin
					if (stat.out_free) begin
						j_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					j_q <= j_q + IW'(1);
					if (col_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (stat.row_done) begin
						if (row_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= ST_START;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/mvr_datapath.sv */
// ----------------------------------------------------------------------------
// mvr_datapath
// Element stores, multiply-accumulate pipeline, residual and output register
// ----------------------------------------------------------------------------
module mvr_datapath #(
	parameter int unsigned MAX_ORDER  = 16,
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned IW         = 4,
	parameter int unsigned AW         = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mvr_pkg::cmd_t                  cmd,
	input  logic [IW-1:0]                  rd_row,
	input  logic [IW-1:0]                  rd_col,
	input  logic [mvr_pkg::IDX_BITS-1:0]   ld_row,
	input  logic [mvr_pkg::IDX_BITS-1:0]   ld_col,
	input  logic [mvr_pkg::DATA_BITS-1:0]  ld_value,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [mvr_pkg::IDX_BITS-1:0]   row_out,
	output logic [mvr_pkg::DATA_BITS-1:0]  residual,
	output logic                           saturated,
	output logic                           last,
	output mvr_pkg::stat_t                 stat
);

	localparam int unsigned VB    = VALUE_BITS;
	localparam int unsigned AB    = mvr_pkg::ACC_BITS;
	localparam int unsigned FB    = mvr_pkg::FRAC_BITS;
	localparam int unsigned Depth = MAX_ORDER * MAX_ORDER;

	localparam logic signed [AB-1:0] AccMax = {1'b0, {(AB-1){1'b1}}};
	localparam logic signed [AB-1:0] AccMin = {1'b1, {(AB-1){1'b0}}};
	localparam logic signed [VB-1:0] ResMax = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] ResMin = {1'b1, {(VB-1){1'b0}}};

	function automatic logic signed [AB-1:0] sat_add(
		input logic signed [AB-1:0] a,
		input logic signed [AB-1:0] b
	);
		logic signed [AB-1:0] s;
		s = a + b;
		if (a[AB-1] == b[AB-1] && s[AB-1] != a[AB-1]) begin
			s = a[AB-1] ? AccMin : AccMax;
		end
		return s;
	endfunction

	function automatic logic signed [AB-1:0] sat_sub(
		input logic signed [AB-1:0] a,
		input logic signed [AB-1:0] b
	);
		logic signed [AB-1:0] s;
		s = a - b;
		if (a[AB-1] != b[AB-1] && s[AB-1] != a[AB-1]) begin
			s = a[AB-1] ? AccMin : AccMax;
		end
		return s;
	endfunction

	logic [VB-1:0] mem_a [Depth];
	logic [VB-1:0] mem_x [MAX_ORDER];
	logic [VB-1:0] mem_b [MAX_ORDER];

	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [VB-1:0] wr_data;

	logic                    v_s1, first_s1, last_s1, lrow_s1;
	logic [IW-1:0]           row_s1;
	logic signed [VB-1:0]    a_s1, x_s1, b_s1;

	logic                    v_s2, first_s2, last_s2, lrow_s2;
	logic [IW-1:0]           row_s2;
	logic signed [VB-1:0]    b_s2;
	logic signed [2*VB-1:0]  prod_s2;

	logic signed [AB-1:0]    acc_q;
	logic                    v_s3, lrow_s3;
	logic [IW-1:0]           row_s3;
	logic signed [VB-1:0]    b_s3;

	logic                    v_s4, lrow_s4;
	logic [IW-1:0]           row_s4;
	logic signed [AB-1:0]    diff_s4;

	logic signed [AB-1:0]    acc_in;
	logic signed [AB-1:0]    rhs_scaled;
	logic signed [AB-FB-1:0] shifted;
	logic signed [VB-1:0]    clipped;
	logic                    clip;
	logic                    out_valid_q;

	assign wr_addr = AW'(ld_row) * AW'(MAX_ORDER) + AW'(ld_col);
	assign rd_addr = AW'(rd_row) * AW'(MAX_ORDER) + AW'(rd_col);
	assign wr_data = ld_value[VB-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (cmd.wr_x) begin
			mem_x[IW'(ld_row)] <= wr_data;
		end
		if (cmd.wr_b) begin
			mem_b[IW'(ld_row)] <= wr_data;
		end
		a_s1 <= mem_a[rd_addr];
		x_s1 <= mem_x[rd_col];
		b_s1 <= mem_b[rd_row];
	end

	// pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		lrow_s1  <= cmd.last_row;
		row_s1   <= rd_row;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		lrow_s2  <= lrow_s1;
		row_s2   <= row_s1;
		b_s2     <= b_s1;
		prod_s2  <= a_s1 * x_s1;

		lrow_s3  <= lrow_s2;
		row_s3   <= row_s2;
		b_s3     <= b_s2;

		lrow_s4  <= lrow_s3;
		row_s4   <= row_s3;
		diff_s4  <= sat_sub(acc_q, rhs_scaled);
	end

	assign acc_in     = first_s2 ? '0 : acc_q;
	assign rhs_scaled = AB'(b_s3) <<< FB;

	// row sum in q32.32, cleared by the first column of each row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= sat_add(acc_in, AB'(prod_s2));
		end
	end

	// floor to q16.16 is an arithmetic shift, then clip to the value range
	assign shifted = diff_s4[AB-1:FB];
	assign clip    = (shifted[AB-FB-1:VB-1] != '0) && (shifted[AB-FB-1:VB-1] != '1);
	assign clipped = clip ? (shifted[AB-FB-1] ? ResMin : ResMax) : shifted[VB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s4) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			row_out   <= mvr_pkg::IDX_BITS'(row_s4);
			residual  <= mvr_pkg::DATA_BITS'(clipped);
			saturated <= clip;
			last      <= lrow_s4;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign stat.row_done = v_s4;
	assign stat.out_free = !out_valid_q || m_tready;

endmodule

/* verif/matrix_vector_residual_tb.sv */
// ----------------------------------------------------------------------------
// matrix_vector_residual_tb
// Loads matrix and vector elements, runs computes at several system orders
// and checks every residual row against a fixed-point predictor kept in step
// with each accepted item; both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module matrix_vector_residual_tb;

	localparam int MAX_ORDER  = 16;
	localparam int LONG_HOLD  = 300;
	localparam int QUIET_MAX  = 4000;
	localparam int RAND_ITEMS = 350;

	typedef struct {
		mvr_pkg::action_t   act;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value;
	} item_t;

	typedef struct {
		logic [3:0]  row_out;
		logic [31:0] residual;
		logic        sat;
		logic        last;
	} residual_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = 5'd16;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // row[3:0], col[7:4], value[39:8]
	logic [1:0]  s_tuser = '0;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // row_out[3:0], residual[35:4], zero pad
	logic [0:0]  m_tuser;        // saturated[0]
	logic        m_tlast;

	matrix_vector_residual dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the stores and the order register
	logic signed [31:0] mat_a [MAX_ORDER][MAX_ORDER];
	logic signed [31:0] vec_x [MAX_ORDER];
	logic signed [31:0] vec_b [MAX_ORDER];
	logic [4:0]         order_cfg = 5'd16;

	// generator side: which entries hold a value, order in force
	bit a_written [MAX_ORDER][MAX_ORDER];
	bit x_written [MAX_ORDER];
	bit b_written [MAX_ORDER];
	int gen_order = MAX_ORDER;
	int items_queued = 0;

	item_t     pending_items[$];
	residual_t residuals_due[$];
	item_t     cur_item = '{mvr_pkg::ACT_LOAD_A, 4'd0, 4'd0, 32'sd0};
	bit        holding = 1'b0;
	logic      in_fire = 1'b0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_requests = 0;
	int        hold_served = 0;
	int        quiet_cycles = 0;
	int        mismatches = 0;

	function automatic int eff_order(input logic [4:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_ORDER)
			return MAX_ORDER;
		return int'(v);
	endfunction

	function automatic longint sat_add64(input longint a, input longint b);
		longint s;
		s = a + b;
		if (!a[63] && !b[63] && s[63])
			return 64'sh7fff_ffff_ffff_ffff;
		if (a[63] && b[63] && !s[63])
			return 64'sh8000_0000_0000_0000;
		return s;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		case ($urandom_range(0, 19))
			12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
			18: return $urandom_range(4, 10);
			19: return $urandom_range(20, 60);
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
			3, 4: return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
			default: return $urandom;
		endcase
	endfunction

	// update the stores or work out the residual rows of a compute
	task automatic track_item(input item_t it);
		longint acc;
		longint q;
		int     n;
		residual_t r;
		case (it.act)
			mvr_pkg::ACT_LOAD_A: mat_a[it.row][it.col] = it.value;
			mvr_pkg::ACT_LOAD_X: vec_x[it.row] = it.value;
			mvr_pkg::ACT_LOAD_B: vec_b[it.row] = it.value;
			default: begin
				n = eff_order(order_cfg);
				for (int i = 0; i < n; i++) begin
					acc = 0;
					for (int j = 0; j < n; j++)
						acc = sat_add64(acc, longint'(mat_a[i][j]) * longint'(vec_x[j]));
					// rhs in q32.32, negation cannot overflow
					acc = sat_add64(acc, -(longint'(vec_b[i]) <<< 16));
					q = acc >>> 16;
					r.sat = 1'b0;
					if (q > 64'sd2147483647) begin
						q = 64'sd2147483647;
						r.sat = 1'b1;
					end else if (q < -64'sd2147483648) begin
						q = -64'sd2147483648;
						r.sat = 1'b1;
					end
					r.row_out  = i[3:0];
					r.residual = q[31:0];
					r.last     = (i == n - 1);
					residuals_due.push_back(r);
				end
			end
		endcase
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic queue_load(input mvr_pkg::action_t act, input int row, input int col,
			input logic signed [31:0] value);
		item_t it;
		it = '{act, row[3:0], col[3:0], value};
		case (act)
			mvr_pkg::ACT_LOAD_A: a_written[row][col] = 1'b1;
			mvr_pkg::ACT_LOAD_X: x_written[row] = 1'b1;
			default: b_written[row] = 1'b1;
		endcase
		pending_items.push_back(it);
		items_queued++;
	endtask

	// first write whatever the current order reads and has never been loaded
	task automatic push_compute();
		item_t it;
		for (int i = 0; i < gen_order; i++) begin
			for (int j = 0; j < gen_order; j++)
				if (!a_written[i][j])
					queue_load(mvr_pkg::ACT_LOAD_A, i, j, rand_value());
			if (!x_written[i])
				queue_load(mvr_pkg::ACT_LOAD_X, i, 0, rand_value());
			if (!b_written[i])
				queue_load(mvr_pkg::ACT_LOAD_B, i, 0, rand_value());
		end
		it = '{mvr_pkg::ACT_COMPUTE, 4'($urandom), 4'($urandom), $urandom};
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || holding || residuals_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_order(input logic [4:0] v);
		wait_drained();
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		order_cfg = v;
		gen_order = eff_order(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender: loads wait until a running compute has delivered every row
	always @(negedge clk) begin
		if (in_fire) begin
			track_item(cur_item);
			holding = 1'b0;
			gap_left = gap_len();
		end
		if (!holding) begin
			if (gap_left > 0)
				gap_left--;
			else if (pending_items.size() != 0 &&
					(pending_items[0].act == mvr_pkg::ACT_COMPUTE ||
					residuals_due.size() == 0)) begin
				cur_item = pending_items.pop_front();
				holding = 1'b1;
			end
		end
		s_tvalid <= holding;
		s_tdata  <= {cur_item.value, cur_item.col, cur_item.row};
		s_tuser  <= cur_item.act;
	end

	// receiver: random stalls, plus a long hold when asked for
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served++;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		residual_t want;
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (residuals_due.size() == 0) begin
				note_mismatch($sformatf("unexpected item row %0d residual %h",
					m_tdata[3:0], m_tdata[35:4]));
			end else begin
				want = residuals_due.pop_front();
				if (m_tdata[3:0] !== want.row_out || m_tdata[35:4] !== want.residual ||
						m_tuser[0] !== want.sat || m_tlast !== want.last)
					note_mismatch($sformatf(
						"expected row %0d res %h sat %b last %b, got row %0d res %h sat %b last %b",
						want.row_out, want.residual, want.sat, want.last,
						m_tdata[3:0], m_tdata[35:4], m_tuser[0], m_tlast));
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_MAX)
			@(posedge clk);
		$display("matrix_vector_residual test failed");
		$finish;
	end

	initial begin
		int start;
		int pick;
		int n;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-element system: clipping high and low, a negative residual just below minus one half
		set_order(5'd1);
		queue_load(mvr_pkg::ACT_LOAD_A, 0, 0, 32'sh7fff_ffff);
		queue_load(mvr_pkg::ACT_LOAD_X, 0, 0, 32'sh7fff_ffff);
		queue_load(mvr_pkg::ACT_LOAD_B, 0, 0, 32'sh8000_0000);
		push_compute();
		queue_load(mvr_pkg::ACT_LOAD_A, 0, 0, 32'sh8000_0000);
		push_compute();
		queue_load(mvr_pkg::ACT_LOAD_A, 0, 0, 32'sh0001_0000);
		queue_load(mvr_pkg::ACT_LOAD_X, 0, 0, 32'shffff_8000);
		queue_load(mvr_pkg::ACT_LOAD_B, 0, 0, 32'sh0000_0001);
		push_compute();
		queue_load(mvr_pkg::ACT_LOAD_A, 15, 15, 32'sd0);
		queue_load(mvr_pkg::ACT_LOAD_X, 15, 9, 32'sd0);
		queue_load(mvr_pkg::ACT_LOAD_B, 15, 6, 32'sd0);

		// order zero behaves as one
		set_order(5'd0);
		queue_load(mvr_pkg::ACT_LOAD_X, 0, 0, 32'sd1);
		push_compute();

		// accumulator overflow upwards on row 0, subtract overflow on row 1
		set_order(5'd2);
		queue_load(mvr_pkg::ACT_LOAD_A, 0, 0, 32'sh8000_0000);
		queue_load(mvr_pkg::ACT_LOAD_A, 0, 1, 32'sh8000_0000);
		queue_load(mvr_pkg::ACT_LOAD_A, 1, 0, 32'sh7fff_ffff);
		queue_load(mvr_pkg::ACT_LOAD_A, 1, 1, 32'sh7fff_ffff);
		queue_load(mvr_pkg::ACT_LOAD_X, 0, 0, 32'sh8000_0000);
		queue_load(mvr_pkg::ACT_LOAD_X, 1, 0, 32'sh8000_0000);
		queue_load(mvr_pkg::ACT_LOAD_B, 0, 0, 32'sh8000_0000);
		queue_load(mvr_pkg::ACT_LOAD_B, 1, 0, 32'sh7fff_ffff);
		push_compute();

		// output held off while computes keep coming
		set_order(5'd4);
		@(posedge clk);
		hold_requests++;
		repeat (6) push_compute();

		start = items_queued;
		pick = 0;
		while (items_queued - start < RAND_ITEMS) begin
			if (pick == 0)
				set_order(5'd31);
			else if (pick == 1)
				set_order(5'd16);
			else
				case ($urandom_range(0, 19))
					0: set_order(5'd0);
					1: set_order(5'($urandom_range(16, 31)));
					2, 3: set_order(5'($urandom_range(7, 15)));
					default: set_order(5'($urandom_range(1, 6)));
				endcase
			n = gen_order;
			repeat ($urandom_range(1, 4)) begin
				repeat ($urandom_range(0, 10))
					if ($urandom_range(0, 4) == 0)
						queue_load(mvr_pkg::action_t'($urandom_range(0, 2)),
							$urandom_range(0, 15), $urandom_range(0, 15), rand_value());
					else
						queue_load(mvr_pkg::action_t'($urandom_range(0, 2)),
							$urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_value());
				push_compute();
			end
			pick++;
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("matrix_vector_residual test passed");
		else
			$display("matrix_vector_residual test failed");
		$finish;
	end

endmodule

/* files.f */
sv/mvr_pkg.sv
sv/mvr_ctrl.sv
sv/mvr_datapath.sv
sv/matrix_vector_residual.sv
verif/matrix_vector_residual_tb.sv
